@@ design/tfl_pkg.sv @@
// Shared types, widths and register codes of the text field locator.
package tfl_pkg;

    // Field widths of the stream items
    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 10;

    // Configuration port widths and default line limit
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int LINE_LIMIT_DEF = 512;

    // Locator counter widths
    localparam int COUNT_W = 8;
    localparam int SKIP_W  = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIELD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE_SKIP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FIELD_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE_SKIP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_LEADING      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_TRAILING     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR         = 3'd6;

    // Locator phase: walk fields, skip blanks, skip bytes, done
    typedef enum logic [3:0] {
        PH_WALK  = 4'b0001,
        PH_BLANK = 4'b0010,
        PH_BYTES = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    // Per-locator walk state
    typedef struct packed {
        t_phase               phase;
        logic [COUNT_W-1:0]   passed;
        logic [SKIP_W-1:0]    left;
    } t_loc;

endpackage

@@ design/tfl_in_if.sv @@
// Input channel: one line byte or a line end marker per transfer.
interface tfl_in_if;
    import tfl_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              line_end;

    modport source (output valid, output line_byte, output line_end, input ready);
    modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

@@ design/tfl_out_if.sv @@
// Output channel: located field offsets and the overlong-line flag.
interface tfl_out_if;
    import tfl_pkg::*;

    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] field_start;
    logic [OFFSET_W-1:0] field_end;
    logic                line_too_long;

    modport source (output valid, output field_start, output field_end,
                    output line_too_long, input ready);
    modport sink   (input valid, input field_start, input field_end,
                    input line_too_long, output ready);
endinterface

@@ design/text_field_locator_core.sv @@
// Top level of the text field locator: per-byte field walk and result register.
//
// Usage: a line streams in on i_in, one byte per transfer, closed by a transfer
// with line_end set (its line_byte is ignored). For each line end one result
// leaves on o_out: field_start and field_end offsets of the configured field
// and line_too_long when the line ran past LINE_LIMIT bytes (offsets then
// saturate at the limit). Byte transfers produce no result.
// Throughput: one input transfer per cycle while i_in is ready, bytes and
// line ends alike; a byte updates only line state, both locators included.
// Latency: the result is valid the cycle after the line end transfer, from a
// single output register.
// Stall: while o_out holds an untaken result, i_in stays ready only if that
// result is taken in the same cycle; otherwise input waits.
// Reset: synchronous, active low; clears line state and the result valid flag,
// and loads register defaults (all zero, end field count -1 meaning line end).
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high;
// unknown indexes are dropped. Writes take effect from the next byte.
module text_field_locator_core #(
    parameter int LINE_LIMIT = tfl_pkg::LINE_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tfl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tfl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tfl_in_if.sink                          i_in,
    tfl_out_if.source                       o_out
);
    import tfl_pkg::*;

    localparam int POS_W = $clog2(LINE_LIMIT + 1);

    // Configuration registers
    logic [COUNT_W-1:0]     r_start_count;
    logic [SKIP_W-1:0]      r_start_skip;
    logic signed [8:0]      r_end_count;
    logic [SKIP_W-1:0]      r_end_skip;
    logic                   r_skip_blanks;
    logic                   r_trim;
    logic [BYTE_W-1:0]      r_sep;

    // Line state
    logic [POS_W-1:0]       r_pos;
    logic                   r_in_word;
    t_loc                   r_start;
    t_loc                   r_end;
    logic [POS_W-1:0]       r_start_off;
    logic [POS_W-1:0]       r_end_off;
    logic [POS_W-1:0]       r_last_nb;
    logic [POS_W-1:0]       r_trim_lim;
    logic                   r_ovf;

    // Result register
    logic                   r_out_valid;
    logic [OFFSET_W-1:0]    r_out_start;
    logic [OFFSET_W-1:0]    r_out_end;
    logic                   r_out_long;

    logic                   in_acc;
    logic                   byte_acc;
    logic                   end_acc;
    logic [BYTE_W-1:0]      c;
    logic                   blank;
    logic                   end_neg;
    logic                   room;
    t_loc                   n_start;
    t_loc                   n_end;
    logic [POS_W-1:0]       res_s;
    logic [POS_W-1:0]       res_ep;
    logic [POS_W-1:0]       res_tl;
    logic [POS_W-1:0]       res_pick;
    logic [POS_W-1:0]       res_e;

    // Advance one locator over the current byte
    function automatic t_loc f_locate(
        input t_loc                st,
        input logic [COUNT_W-1:0]  count,
        input logic [SKIP_W-1:0]   nskip,
        input logic [BYTE_W-1:0]   cb,
        input logic                bl,
        input logic                in_word,
        input logic [BYTE_W-1:0]   sep,
        input logic                skipbl
    );
        t_loc n;
        logic stop;
        n    = st;
        stop = 1'b0;
        if (n.phase == PH_WALK) begin
            if (n.passed == count) begin
                n.phase = skipbl ? PH_BLANK : PH_BYTES;
                n.left  = nskip;
            end else if (sep != '0) begin
                if (cb == sep) n.passed = n.passed + 1'b1;
                stop = 1'b1;
            end else if (bl && in_word) begin
                n.passed = n.passed + 1'b1;
                if (n.passed == count) begin
                    // this blank belongs to the next phase
                    n.phase = skipbl ? PH_BLANK : PH_BYTES;
                    n.left  = nskip;
                end else begin
                    stop = 1'b1;
                end
            end else begin
                stop = 1'b1;
            end
        end
        if (!stop && n.phase == PH_BLANK) begin
            if (bl) stop = 1'b1;
            else    n.phase = PH_BYTES;
        end
        if (!stop && n.phase == PH_BYTES) begin
            if (n.left == '0) n.phase = PH_DONE;
            else              n.left  = n.left - 1'b1;
        end
        return n;
    endfunction

    // Handshake: accept while the result register is empty or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign byte_acc   = in_acc && !i_in.line_end;
    assign end_acc    = in_acc && i_in.line_end;

    assign o_out.valid         = r_out_valid;
    assign o_out.field_start   = r_out_start;
    assign o_out.field_end     = r_out_end;
    assign o_out.line_too_long = r_out_long;

    // Classify the byte and step both locators
    always_comb begin
        c       = i_in.line_byte;
        blank   = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
        end_neg = r_end_count[8];
        room    = r_pos < POS_W'(LINE_LIMIT);
        n_start = f_locate(r_start, r_start_count, r_start_skip, c, blank,
                           r_in_word, r_sep, r_skip_blanks);
        n_end   = f_locate(r_end, r_end_count[7:0], r_end_skip, c, blank,
                           r_in_word, r_sep, r_skip_blanks);
    end

    // Resolve the field bounds at line end
    always_comb begin
        res_s    = (r_start.phase == PH_DONE) ? r_start_off : r_pos;
        res_ep   = (r_end.phase == PH_DONE) ? r_end_off : r_pos;
        res_tl   = (r_end.phase == PH_DONE) ? r_trim_lim : r_last_nb;
        res_pick = r_trim ? res_tl : res_ep;
        if (end_neg)               res_e = r_pos;
        else if (res_pick < res_s) res_e = res_s;
        else                       res_e = res_pick;
    end

    // Control state: configuration, line state, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_count <= '0;
            r_start_skip  <= '0;
            r_end_count   <= -9'sd1;
            r_end_skip    <= '0;
            r_skip_blanks <= 1'b0;
            r_trim        <= 1'b0;
            r_sep         <= '0;
            r_pos         <= '0;
            r_in_word     <= 1'b0;
            r_start       <= '{phase: PH_WALK, passed: '0, left: '0};
            r_end         <= '{phase: PH_WALK, passed: '0, left: '0};
            r_start_off   <= '0;
            r_end_off     <= '0;
            r_last_nb     <= '0;
            r_trim_lim    <= '0;
            r_ovf         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_FIELD_COUNT: r_start_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_START_BYTE_SKIP:   r_start_skip  <= i_cfg_data;
                    CFG_END_FIELD_COUNT:   r_end_count   <= i_cfg_data;
                    CFG_END_BYTE_SKIP:     r_end_skip    <= i_cfg_data;
                    CFG_SKIP_LEADING:      r_skip_blanks <= i_cfg_data[0];
                    CFG_TRIM_TRAILING:     r_trim        <= i_cfg_data[0];
                    CFG_SEPARATOR:         r_sep         <= i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end

            // Line state: clear at line end, advance on each byte within the line limit
            if (end_acc) begin
                r_pos       <= '0;
                r_in_word   <= 1'b0;
                r_start     <= '{phase: PH_WALK, passed: '0, left: '0};
                r_end       <= '{phase: PH_WALK, passed: '0, left: '0};
                r_start_off <= '0;
                r_end_off   <= '0;
                r_last_nb   <= '0;
                r_trim_lim  <= '0;
                r_ovf       <= 1'b0;
            end else if (byte_acc) begin
                if (!room) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_start <= n_start;
                    if (r_start.phase != PH_DONE && n_start.phase == PH_DONE)
                        r_start_off <= r_pos;
                    if (!end_neg && r_end.phase != PH_DONE) begin
                        r_end <= n_end;
                        if (n_end.phase == PH_DONE) begin
                            r_end_off  <= r_pos;
                            r_trim_lim <= r_last_nb;
                        end
                    end
                    if (!blank) r_last_nb <= r_pos + 1'b1;
                    r_in_word <= !blank;
                    r_pos     <= r_pos + 1'b1;
                end
            end

            // Result valid: load on line end, drop once transferred
            if (end_acc)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (end_acc) begin
            r_out_start <= OFFSET_W'(res_s);
            r_out_end   <= OFFSET_W'(res_e);
            r_out_long  <= r_ovf;
        end
    end

endmodule

@@ design/tfl_checker.sv @@
// Port-level checks of the text field locator, bound to the top level.
module tfl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_line_end,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [tfl_pkg::OFFSET_W-1:0]   i_out_start,
    input logic [tfl_pkg::OFFSET_W-1:0]   i_out_end,
    input logic                           i_out_long
);
    import tfl_pkg::*;

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_start)
            && $stable(i_out_end) && $stable(i_out_long))
        else $error("stalled result changed");

    // Leave reset with no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Raise a result only after a line end transfer
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid ##1 i_out_valid |-> $past(i_in_valid && i_in_ready && i_in_line_end))
        else $error("result without line end");

    // Keep the field end at or past its start
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_end >= i_out_start)
        else $error("field end below field start");

endmodule

bind text_field_locator_core tfl_checker u_tfl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_line_end (i_in.line_end),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_start   (o_out.field_start),
    .i_out_end     (o_out.field_end),
    .i_out_long    (o_out.line_too_long)
);
